>>> rtl/occupancy_grid_ray_update_top_assert.svh
// Assertion macros shared by the occupancy grid RTL.
`ifndef OCCUPANCY_GRID_RAY_UPDATE_TOP_ASSERT_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define OGRU_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define OGRU_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ogru_pkg.sv
package ogru_pkg;

  localparam int COORD_BITS   = 16;
  localparam int CELL_BITS    = 8;
  localparam int COUNT_BITS   = 9;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Register indexes on the config port
  localparam logic [CFG_IDX_BITS-1:0] REG_FREE_INC = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OCC_INC  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SAT_LOW  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SAT_HIGH = 2'd3;

  // Register reset values
  localparam logic signed [CELL_BITS-1:0] RST_FREE_INC = 8'shFF; // -1
  localparam logic signed [CELL_BITS-1:0] RST_OCC_INC  = 8'sh04; //  4
  localparam logic signed [CELL_BITS-1:0] RST_SAT_LOW  = 8'shCE; // -50
  localparam logic signed [CELL_BITS-1:0] RST_SAT_HIGH = 8'sh32; //  50

  typedef struct packed {
    logic                         op;
    logic signed [COORD_BITS-1:0] start_col;
    logic signed [COORD_BITS-1:0] start_row;
    logic signed [COORD_BITS-1:0] end_col;
    logic signed [COORD_BITS-1:0] end_row;
  } ogru_item_t;

  typedef struct packed {
    logic signed [CELL_BITS-1:0] cell_value;
    logic [COUNT_BITS-1:0]       cells_updated;
    logic                        end_in_grid;
  } ogru_result_t;

  typedef struct packed {
    logic signed [CELL_BITS-1:0] free_inc;
    logic signed [CELL_BITS-1:0] occ_inc;
    logic signed [CELL_BITS-1:0] sat_low;
    logic signed [CELL_BITS-1:0] sat_high;
  } ogru_cfg_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic                         is_read;
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic [COORD_BITS-1:0]        dx;
    logic [COORD_BITS-1:0]        dy;
    logic                         sx_neg;
    logic                         sy_neg;
    logic                         end_in;
  } ogru_cmd_t;

  function automatic logic in_grid(input logic signed [COORD_BITS-1:0] col,
                                   input logic signed [COORD_BITS-1:0] row,
                                   input int cols, input int rows);
    return (col >= 0) && (int'(col) < cols) && (row >= 0) && (int'(row) < rows);
  endfunction

endpackage

>>> rtl/ogru_ram.sv
module ogru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port (read returns old data)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/ogru_front.sv
module ogru_front #(
  parameter int GRID_COLS = 256,
  parameter int GRID_ROWS = 256
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  ogru_pkg::ogru_item_t in_data,
  input  logic               fifo_full,
  input  logic               clearing,
  output logic               push,
  output ogru_pkg::ogru_cmd_t cmd
);
  import ogru_pkg::*;

  logic signed [COORD_BITS:0] dcol, drow;

  // Accept while the queue has room and the grid is not being cleared
  assign in_ready = !fifo_full && !clearing;
  assign push     = in_valid && in_ready;

  // Signed deltas, one bit wider than the coordinates
  assign dcol = {in_data.end_col[COORD_BITS-1], in_data.end_col}
              - {in_data.start_col[COORD_BITS-1], in_data.start_col};
  assign drow = {in_data.end_row[COORD_BITS-1], in_data.end_row}
              - {in_data.start_row[COORD_BITS-1], in_data.start_row};

  // Classify the transaction and precompute the line setup
  always_comb begin
    cmd.is_read = in_data.op;
    cmd.x0      = in_data.start_col;
    cmd.y0      = in_data.start_row;
    cmd.x1      = in_data.end_col;
    cmd.y1      = in_data.end_row;
    cmd.sx_neg  = !(in_data.start_col < in_data.end_col);
    cmd.sy_neg  = !(in_data.start_row < in_data.end_row);
    cmd.dx      = dcol[COORD_BITS] ? COORD_BITS'(-dcol) : dcol[COORD_BITS-1:0];
    cmd.dy      = drow[COORD_BITS] ? COORD_BITS'(-drow) : drow[COORD_BITS-1:0];
    if (in_data.op) begin
      cmd.end_in = in_grid(in_data.start_col, in_data.start_row, GRID_COLS, GRID_ROWS);
    end else begin
      cmd.end_in = in_grid(in_data.end_col, in_data.end_row, GRID_COLS, GRID_ROWS);
    end
  end

endmodule

>>> rtl/ogru_fifo.sv
`include "occupancy_grid_ray_update_top_assert.svh"

module ogru_fifo #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ogru_pkg::ogru_cmd_t din,
  input  logic               pop,
  output ogru_pkg::ogru_cmd_t dout,
  output logic               full,
  output logic               empty
);
  import ogru_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ogru_cmd_t       entries [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  `OGRU_ASSERT_NOW(a_no_push_full, clk, rst, push, !full, "queue push while full")
  `OGRU_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, !empty, "queue pop while empty")

endmodule

>>> rtl/ogru_back.sv
`include "occupancy_grid_ray_update_top_assert.svh"

module ogru_back #(
  parameter int GRID_COLS = 256,
  parameter int GRID_ROWS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ogru_pkg::ogru_cfg_t    cfg,
  input  logic                  fifo_empty,
  input  ogru_pkg::ogru_cmd_t    head,
  output logic                  fifo_pop,
  output logic                  clearing,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ogru_pkg::ogru_result_t out_data
);
  import ogru_pkg::*;

  localparam int CELLS = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CIW   = $clog2(GRID_COLS);
  localparam int RIW   = $clog2(GRID_ROWS);
  localparam int EW    = COORD_BITS + 2;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CLEAR = 3'b010,
    S_WALK  = 3'b100
  } state_t;

  state_t state;
  logic [AW-1:0] clr_addr;

  // Line walker registers
  logic signed [COORD_BITS-1:0] cur_col, cur_row, tgt_col, tgt_row;
  logic [COORD_BITS-1:0]        dx, dy;
  logic                         sx_neg, sy_neg, is_read, end_in;
  logic signed [EW-1:0]         err;
  logic [COUNT_BITS-1:0]        cnt;

  logic                         at_end, cur_in, issue, step_x, step_y, cnt_inc;
  logic signed [EW:0]           e2, dx_w, dy_w;
  logic signed [EW-1:0]         dx_e, dy_e, err_next;
  logic [COUNT_BITS-1:0]        cnt_next;
  logic [AW-1:0]                cur_addr;

  // Write stage registers
  logic                         w_valid, w_write, w_last, w_read, w_in, w_end_in;
  logic [AW-1:0]                w_addr;
  logic signed [CELL_BITS-1:0]  w_delta;
  logic [COUNT_BITS-1:0]        w_count;

  // Last write, forwarded into the next read-modify-write
  logic                         fwd_valid;
  logic [AW-1:0]                fwd_addr;
  logic [CELL_BITS-1:0]         fwd_data;

  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_waddr;
  logic [CELL_BITS-1:0]         ram_wdata, ram_rdata;

  logic signed [CELL_BITS-1:0]  old_val, new_val;
  logic signed [CELL_BITS:0]    sum, sat_hi_e, sat_lo_e;

  logic                         res_valid;
  ogru_result_t                 res;

  assign clearing  = (state == S_CLEAR);
  assign fifo_pop  = (state == S_IDLE) && !fifo_empty;
  assign out_valid = res_valid;
  assign out_data  = res;

  // Current cell: position test, address, end test
  assign cur_in   = in_grid(cur_col, cur_row, GRID_COLS, GRID_ROWS);
  assign cur_addr = AW'(AW'(cur_row[RIW-1:0]) * AW'(GRID_COLS)) + AW'(cur_col[CIW-1:0]);
  assign at_end   = is_read || ((cur_col == tgt_col) && (cur_row == tgt_row));

  // A final cell goes out only when the result slot will be free for it
  assign issue = (state == S_WALK)
               && (!at_end || (!(w_valid && w_last) && (!res_valid || out_ready)));

  // Bresenham error step
  assign dx_e   = $signed({{(EW - COORD_BITS){1'b0}}, dx});
  assign dy_e   = $signed({{(EW - COORD_BITS){1'b0}}, dy});
  assign dx_w   = $signed({{(EW + 1 - COORD_BITS){1'b0}}, dx});
  assign dy_w   = $signed({{(EW + 1 - COORD_BITS){1'b0}}, dy});
  assign e2     = $signed({err, 1'b0});
  assign step_x = (e2 > -dy_w);
  assign step_y = (e2 < dx_w);
  assign err_next = err - (step_x ? dy_e : EW'(0)) + (step_y ? dx_e : EW'(0));

  // Saturating update count
  assign cnt_inc  = cur_in && !is_read && (cnt != COUNT_MAX);
  assign cnt_next = cnt + COUNT_BITS'(cnt_inc);

  // Read-modify-write: add, then clamp high first, low second
  assign old_val  = (fwd_valid && (fwd_addr == w_addr)) ? $signed(fwd_data)
                                                         : $signed(ram_rdata);
  assign sum      = {old_val[CELL_BITS-1], old_val} + {w_delta[CELL_BITS-1], w_delta};
  assign sat_hi_e = {cfg.sat_high[CELL_BITS-1], cfg.sat_high};
  assign sat_lo_e = {cfg.sat_low[CELL_BITS-1], cfg.sat_low};

  always_comb begin
    if (sum > sat_hi_e) begin
      new_val = cfg.sat_high;
    end else if (sum < sat_lo_e) begin
      new_val = cfg.sat_low;
    end else begin
      new_val = sum[CELL_BITS-1:0];
    end
  end

  // Grid port muxing: clearing pass or write stage
  assign ram_we    = clearing || (w_valid && w_write);
  assign ram_waddr = clearing ? clr_addr : w_addr;
  assign ram_wdata = clearing ? '0 : new_val;
  assign ram_re    = issue && cur_in;

  ogru_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cur_addr),
    .rdata (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      w_valid   <= 1'b0;
      fwd_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!fifo_empty) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (issue && at_end) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
      w_valid   <= issue;
      fwd_valid <= ram_we;
      if (w_valid && w_last) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Walker datapath
  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      cur_col <= head.x0;
      cur_row <= head.y0;
      tgt_col <= head.x1;
      tgt_row <= head.y1;
      dx      <= head.dx;
      dy      <= head.dy;
      sx_neg  <= head.sx_neg;
      sy_neg  <= head.sy_neg;
      is_read <= head.is_read;
      end_in  <= head.end_in;
      err     <= $signed({{(EW - COORD_BITS){1'b0}}, head.dx})
               - $signed({{(EW - COORD_BITS){1'b0}}, head.dy});
      cnt     <= '0;
    end else if (issue) begin
      cnt <= cnt_next;
      if (!at_end) begin
        err <= err_next;
        if (step_x) begin
          cur_col <= sx_neg ? cur_col - 1'b1 : cur_col + 1'b1;
        end
        if (step_y) begin
          cur_row <= sy_neg ? cur_row - 1'b1 : cur_row + 1'b1;
        end
      end
    end
  end

  // Write stage, forwarding and result payload
  always_ff @(posedge clk) begin
    if (issue) begin
      w_addr   <= cur_addr;
      w_write  <= cur_in && !is_read;
      w_delta  <= at_end ? cfg.occ_inc : cfg.free_inc;
      w_last   <= at_end;
      w_read   <= is_read;
      w_in     <= cur_in;
      w_end_in <= end_in;
      w_count  <= cnt_next;
    end
    fwd_addr <= ram_waddr;
    fwd_data <= ram_wdata;
    if (w_valid && w_last) begin
      res.cell_value    <= (w_read && w_in) ? old_val : '0;
      res.cells_updated <= w_read ? '0 : w_count;
      res.end_in_grid   <= w_end_in;
    end
  end

  `OGRU_ASSERT_NOW(a_res_slot_free, clk, rst, w_valid && w_last, !res_valid || out_ready, "result overwritten")
  `OGRU_ASSERT_NOW(a_no_read_in_clear, clk, rst, state == S_CLEAR, !ram_re && !w_valid, "grid access during clear")
  `OGRU_ASSERT_NEXT(a_last_gives_result, clk, rst, w_valid && w_last, out_valid, "final cell gave no result")

endmodule

>>> rtl/occupancy_grid_ray_update_top.sv
// An accepted item is queued, then walked cell by cell; the final cell's write stage loads the
// result register behind out_valid. Items are walked one at a time by the one-cell-a-cycle
// read-modify-write on the single grid memory, which waits at a final cell while the result
// slot is full; two items queue ahead of it. Reset (rst, synchronous) restores the register
// defaults, empties the queue and runs a clearing pass that zeroes all GRID_COLS * GRID_ROWS
// grid cells; in_ready is low during the pass, config writes are taken.
module occupancy_grid_ray_update_top #(
  parameter int GRID_COLS = 256,
  parameter int GRID_ROWS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ogru_pkg::ogru_item_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ogru_pkg::ogru_result_t                out_data,
  input  logic                                 cfg_write_en,
  input  logic [ogru_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ogru_pkg::CELL_BITS-1:0]       cfg_data
);
  import ogru_pkg::*;

  localparam int QUEUE_DEPTH = 2;

  ogru_cfg_t cfg;
  ogru_cmd_t cmd, head;
  logic      push, pop, fifo_full, fifo_empty, clearing;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.free_inc <= RST_FREE_INC;
      cfg.occ_inc  <= RST_OCC_INC;
      cfg.sat_low  <= RST_SAT_LOW;
      cfg.sat_high <= RST_SAT_HIGH;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_FREE_INC: cfg.free_inc <= $signed(cfg_data);
        REG_OCC_INC:  cfg.occ_inc  <= $signed(cfg_data);
        REG_SAT_LOW:  cfg.sat_low  <= $signed(cfg_data);
        REG_SAT_HIGH: cfg.sat_high <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  ogru_front #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .fifo_full (fifo_full),
    .clearing  (clearing),
    .push      (push),
    .cmd       (cmd)
  );

  ogru_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd),
    .pop   (pop),
    .dout  (head),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  ogru_back #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fifo_empty (fifo_empty),
    .head       (head),
    .fifo_pop   (pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
